// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the RTL. Each use expects i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define SCPROF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Condition that must never hold outside reset.
`define SCPROF_ASSERT_NEVER(label, expr, msg) \
    `SCPROF_ASSERT(label, !(expr), msg)

`endif

// ----- sv/scprof_pkg.sv -----
package scprof_pkg;

    localparam int CALL_COUNT   = 512;
    localparam int THREAD_SLOTS = 64;

    localparam int CALL_IDX_W = $clog2(CALL_COUNT);
    localparam int SLOT_IDX_W = $clog2(THREAD_SLOTS);

    localparam int OP_W     = 3;
    localparam int SLOT_W   = 6;
    localparam int CALL_W   = 9;
    localparam int TS_W     = 64;
    localparam int STATUS_W = 3;
    localparam int CNT_W    = 32;

    // Event codes
    localparam logic [OP_W-1:0] OP_ENTRY   = 3'd0;
    localparam logic [OP_W-1:0] OP_EXIT    = 3'd1;
    localparam logic [OP_W-1:0] OP_CREATE  = 3'd2;
    localparam logic [OP_W-1:0] OP_EXITED  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ    = 3'd4;

    // Result codes
    localparam logic [STATUS_W-1:0] ST_COUNTED      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISSED_ENTRY = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISMATCH     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISSED_EXIT  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REGISTERED   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DONE         = 3'd5;

    typedef struct packed {
        logic [TS_W-1:0]  time_ns;
        logic [CNT_W-1:0] calls;
        logic [CNT_W-1:0] errors;
        logic [CNT_W-1:0] missed_entries;
        logic [CNT_W-1:0] missed_exits;
    } t_stat_row;

    typedef struct packed {
        logic [CALL_W-1:0] call;
        logic [TS_W-1:0]   entry_ns;
    } t_thread_row;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_ACCUM,
        S_MISS
    } t_state;

    typedef enum logic [1:0] {
        RD_INPUT,
        RD_HELD,
        RD_PENDING
    } t_rd_sel;

    typedef struct packed {
        logic    accept;
        logic    clear_step;
        logic    exec_commit;
        logic    elapsed_load;
        logic    accum_commit;
        logic    miss_commit;
        logic    out_load;
        t_rd_sel rd_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic match;
        logic mismatch;
        logic out_free;
    } t_dp_stat;

    function automatic logic [CNT_W-1:0] sat_inc32(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + CNT_W'(1);
    endfunction

    function automatic logic [TS_W-1:0] sat_add64(input logic [TS_W-1:0] a,
                                                  input logic [TS_W-1:0] b);
        logic [TS_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TS_W] ? '1 : s[TS_W-1:0];
    endfunction

endpackage

// ----- sv/syscall_entry_exit_profiler.sv -----
// Channel  | valid   | ready   | payload
// ---------+---------+---------+----------------------------------------------
// event    | i_valid | o_ready | i_op i_thread_slot i_call_number
//          |         |         | i_call_failed i_timestamp_ns
// result   | o_valid | i_ready | o_status o_row_time_ns o_row_calls o_row_errors
//          |         |         | o_row_missed_entries o_row_missed_exits
//
// One event at a time: a matching exit passes an accumulate state (elapsed time is
// registered before the saturating add), and a mismatching exit a second update state
// (two statistics rows go one after the other through the one write port of the
// statistics memory). After reset a clearing pass zeroes the 512 statistics rows, one per
// cycle, and no event is taken until the pass is done.
// A result waits in the output register; the next event is taken and held until it goes.
module syscall_entry_exit_profiler
    import scprof_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [OP_W-1:0]     i_op,
    input  logic [SLOT_W-1:0]   i_thread_slot,
    input  logic [CALL_W-1:0]   i_call_number,
    input  logic                i_call_failed,
    input  logic [TS_W-1:0]     i_timestamp_ns,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [TS_W-1:0]     o_row_time_ns,
    output logic [CNT_W-1:0]    o_row_calls,
    output logic [CNT_W-1:0]    o_row_errors,
    output logic [CNT_W-1:0]    o_row_missed_entries,
    output logic [CNT_W-1:0]    o_row_missed_exits
);

    t_dp_cmd  cmd;
    t_dp_stat dp_stat;

    scprof_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_dp    (dp_stat),
        .o_cmd   (cmd)
    );

    scprof_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_stat               (dp_stat),
        .i_op                 (i_op),
        .i_thread_slot        (i_thread_slot),
        .i_call_number        (i_call_number),
        .i_call_failed        (i_call_failed),
        .i_timestamp_ns       (i_timestamp_ns),
        .i_out_ready          (i_ready),
        .o_valid              (o_valid),
        .o_status             (o_status),
        .o_row_time_ns        (o_row_time_ns),
        .o_row_calls          (o_row_calls),
        .o_row_errors         (o_row_errors),
        .o_row_missed_entries (o_row_missed_entries),
        .o_row_missed_exits   (o_row_missed_exits)
    );

endmodule

// ----- sv/scprof_ram.sv -----
module scprof_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/scprof_ctrl.sv -----
module scprof_ctrl
    import scprof_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_dp_stat i_dp,
    output t_dp_cmd  o_cmd
);

`include "assert_macros.svh"

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_dp.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_dp.mismatch) begin
                    n_state = S_MISS;
                end else if (i_dp.match) begin
                    n_state = S_ACCUM;
                end else if (i_dp.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_ACCUM, S_MISS: begin
                if (i_dp.out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        o_cmd.rd_sel = RD_HELD;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
            end
            S_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.rd_sel = RD_INPUT;
                o_cmd.accept = i_valid;
            end
            S_EXEC: begin
                // a mismatch fetches the pending call's row for the next cycle
                if (i_dp.mismatch) begin
                    o_cmd.rd_sel      = RD_PENDING;
                    o_cmd.exec_commit = 1'b1;
                end else if (i_dp.match) begin
                    o_cmd.elapsed_load = 1'b1;
                end else if (i_dp.out_free) begin
                    o_cmd.exec_commit = 1'b1;
                    o_cmd.out_load    = 1'b1;
                end
            end
            S_ACCUM: begin
                if (i_dp.out_free) begin
                    o_cmd.accum_commit = 1'b1;
                    o_cmd.out_load     = 1'b1;
                end
            end
            S_MISS: begin
                o_cmd.rd_sel = RD_PENDING;
                if (i_dp.out_free) begin
                    o_cmd.miss_commit = 1'b1;
                    o_cmd.out_load    = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    `SCPROF_ASSERT(a_miss_after_exec,
        (r_state == S_MISS) |-> ($past(r_state) == S_EXEC || $past(r_state) == S_MISS),
        "second row update entered without a mismatching exit")
    `SCPROF_ASSERT(a_clear_complete,
        $fell(r_state == S_CLEAR) |-> $past(i_dp.clear_last),
        "clearing pass left before the last row")

endmodule

// ----- sv/scprof_dp.sv -----
module scprof_dp
    import scprof_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    input  logic [OP_W-1:0]     i_op,
    input  logic [SLOT_W-1:0]   i_thread_slot,
    input  logic [CALL_W-1:0]   i_call_number,
    input  logic                i_call_failed,
    input  logic [TS_W-1:0]     i_timestamp_ns,
    input  logic                i_out_ready,
    output logic                o_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [TS_W-1:0]     o_row_time_ns,
    output logic [CNT_W-1:0]    o_row_calls,
    output logic [CNT_W-1:0]    o_row_errors,
    output logic [CNT_W-1:0]    o_row_missed_entries,
    output logic [CNT_W-1:0]    o_row_missed_exits
);

`include "assert_macros.svh"

    // Held transaction
    logic [OP_W-1:0]   r_op;
    logic              r_live;
    logic [SLOT_W-1:0] r_slot;
    logic [CALL_W-1:0] r_num;
    logic              r_failed;
    logic [TS_W-1:0]   r_ts;
    logic [TS_W-1:0]   r_elapsed;

    logic [THREAD_SLOTS-1:0] r_valid;
    logic [THREAD_SLOTS-1:0] r_pend;
    logic [CALL_IDX_W-1:0]   r_clr_cnt;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    t_stat_row           r_out_row;

    logic [SLOT_IDX_W-1:0] slot_idx;
    logic [CALL_IDX_W-1:0] num_idx;
    logic [CALL_IDX_W-1:0] pend_idx;
    logic                  cur_valid;
    logic                  cur_pend;
    logic                  same_call;
    logic                  exit_pending;
    logic                  n_live;

    t_thread_row           trd;
    t_thread_row           twr;
    logic                  thr_we;
    logic [SLOT_IDX_W-1:0] thr_raddr;

    t_stat_row             srd;
    t_stat_row             swr;
    logic                  stat_we;
    logic [CALL_IDX_W-1:0] stat_waddr;
    logic [CALL_IDX_W-1:0] stat_raddr;

    t_stat_row           ex_row;
    t_stat_row           acc_row;
    t_stat_row           miss_row;
    t_stat_row           ex_out_row;
    logic                ex_we;
    logic [STATUS_W-1:0] ex_status;
    logic                flop_we;
    logic                n_valid_bit;
    logic                n_pend_bit;
    logic [STATUS_W-1:0] n_out_status;
    t_stat_row           n_out_row;

    assign slot_idx     = SLOT_IDX_W'(r_slot);
    assign num_idx      = CALL_IDX_W'(r_num);
    assign pend_idx     = CALL_IDX_W'(trd.call);
    assign cur_valid    = r_valid[slot_idx];
    assign cur_pend     = cur_valid & r_pend[slot_idx];
    assign same_call    = (trd.call == r_num);
    assign exit_pending = r_live && (r_op == OP_EXIT) && cur_pend;

    assign n_live = (i_op <= OP_READ)
                 && (32'(i_thread_slot) < THREAD_SLOTS)
                 && (32'(i_call_number) < CALL_COUNT);

    assign o_stat.clear_last = (r_clr_cnt == CALL_IDX_W'(CALL_COUNT - 1));
    assign o_stat.match      = exit_pending && same_call;
    assign o_stat.mismatch   = exit_pending && !same_call;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    // Read addresses: straight from the ports while idle so data is ready in the next cycle
    always_comb begin
        thr_raddr  = slot_idx;
        stat_raddr = num_idx;
        unique case (i_cmd.rd_sel)
            RD_INPUT: begin
                thr_raddr  = SLOT_IDX_W'(i_thread_slot);
                stat_raddr = CALL_IDX_W'(i_call_number);
            end
            RD_HELD:    stat_raddr = num_idx;
            RD_PENDING: stat_raddr = pend_idx;
            default:    stat_raddr = num_idx;
        endcase
    end

    // Event decode on the fetched thread entry and statistics row
    always_comb begin
        ex_row      = srd;
        ex_out_row  = '0;
        ex_we       = 1'b0;
        ex_status   = ST_DONE;
        flop_we     = 1'b0;
        n_valid_bit = 1'b1;
        n_pend_bit  = 1'b0;
        thr_we      = 1'b0;
        if (r_live) begin
            unique case (r_op)
                OP_ENTRY: begin
                    flop_we    = 1'b1;
                    n_pend_bit = 1'b1;
                    thr_we     = i_cmd.exec_commit;
                    if (cur_pend) begin
                        ex_row.missed_exits = sat_inc32(srd.missed_exits);
                        ex_we     = 1'b1;
                        ex_status = ST_MISSED_EXIT;
                    end
                end
                OP_EXIT: begin
                    if (!cur_valid) begin
                        flop_we   = 1'b1;
                        ex_status = ST_REGISTERED;
                    end else if (!cur_pend || !same_call) begin
                        // the pending call, if any, stays open
                        ex_row.missed_entries = sat_inc32(srd.missed_entries);
                        ex_we     = 1'b1;
                        ex_status = cur_pend ? ST_MISMATCH : ST_MISSED_ENTRY;
                    end
                end
                OP_CREATE: begin
                    flop_we   = 1'b1;
                    ex_status = ST_REGISTERED;
                end
                OP_EXITED: begin
                    flop_we     = 1'b1;
                    n_valid_bit = 1'b0;
                end
                OP_READ: begin
                    ex_out_row = srd;
                end
                default: ex_status = ST_DONE;
            endcase
        end
    end

    always_comb begin
        acc_row         = srd;
        acc_row.time_ns = sat_add64(srd.time_ns, r_elapsed);
        acc_row.calls   = sat_inc32(srd.calls);
        if (r_failed) acc_row.errors = sat_inc32(srd.errors);
        miss_row              = srd;
        miss_row.missed_exits = sat_inc32(srd.missed_exits);
    end

    always_comb begin
        twr.call     = r_num;
        twr.entry_ns = r_ts;
    end

    always_comb begin
        stat_we    = 1'b0;
        stat_waddr = num_idx;
        swr        = ex_row;
        priority if (i_cmd.clear_step) begin
            stat_we    = 1'b1;
            stat_waddr = r_clr_cnt;
            swr        = '0;
        end else if (i_cmd.miss_commit) begin
            stat_we    = 1'b1;
            stat_waddr = pend_idx;
            swr        = miss_row;
        end else if (i_cmd.accum_commit) begin
            stat_we = 1'b1;
            swr     = acc_row;
        end else if (i_cmd.exec_commit) begin
            stat_we = ex_we;
        end
    end

    always_comb begin
        n_out_status = ex_status;
        n_out_row    = ex_out_row;
        priority if (i_cmd.accum_commit) begin
            n_out_status = ST_COUNTED;
            n_out_row    = '0;
        end else if (i_cmd.miss_commit) begin
            n_out_status = ST_MISMATCH;
            n_out_row    = '0;
        end
    end

    scprof_ram #(
        .WIDTH ($bits(t_thread_row)),
        .DEPTH (THREAD_SLOTS)
    ) u_thread_ram (
        .i_clk   (i_clk),
        .i_we    (thr_we),
        .i_waddr (slot_idx),
        .i_wdata (twr),
        .i_raddr (thr_raddr),
        .o_rdata (trd)
    );

    scprof_ram #(
        .WIDTH ($bits(t_stat_row)),
        .DEPTH (CALL_COUNT)
    ) u_stat_ram (
        .i_clk   (i_clk),
        .i_we    (stat_we),
        .i_waddr (stat_waddr),
        .i_wdata (swr),
        .i_raddr (stat_raddr),
        .o_rdata (srd)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op     <= i_op;
            r_live   <= n_live;
            r_slot   <= i_thread_slot;
            r_num    <= i_call_number;
            r_failed <= i_call_failed;
            r_ts     <= i_timestamp_ns;
        end
        if (i_cmd.elapsed_load) begin
            r_elapsed <= r_ts - trd.entry_ns;
        end
        if (i_cmd.out_load) begin
            r_out_status <= n_out_status;
            r_out_row    <= n_out_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_pend      <= '0;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_step) begin
                r_clr_cnt <= r_clr_cnt + CALL_IDX_W'(1);
            end
            if (i_cmd.exec_commit && flop_we) begin
                r_valid[slot_idx] <= n_valid_bit;
                r_pend[slot_idx]  <= n_pend_bit;
            end else if (i_cmd.accum_commit) begin
                r_pend[slot_idx] <= 1'b0;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid              = r_out_valid;
    assign o_status             = r_out_status;
    assign o_row_time_ns        = r_out_row.time_ns;
    assign o_row_calls          = r_out_row.calls;
    assign o_row_errors         = r_out_row.errors;
    assign o_row_missed_entries = r_out_row.missed_entries;
    assign o_row_missed_exits   = r_out_row.missed_exits;

    `SCPROF_ASSERT(a_load_into_free,
        i_cmd.out_load |-> (!r_out_valid || i_out_ready),
        "result overwrote a transaction not yet taken")
    `SCPROF_ASSERT(a_miss_other_row,
        i_cmd.miss_commit |-> (pend_idx != num_idx),
        "mismatch update hit the row of the exiting call")
    `SCPROF_ASSERT_NEVER(a_pend_needs_valid,
        |(r_pend & ~r_valid),
        "pending call on an unregistered thread")

endmodule

// ----- dv/tb.sv -----
module tb;
    import scprof_pkg::*;

    // op codes above OP_READ are unused and only earn a done status
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
    localparam logic [TS_W-1:0] TS_TOP      = '1;
    localparam logic [TS_W-1:0] TS_ZERO     = '0;

    localparam int N_RANDOM     = 395;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 12;
    localparam int N_PLAN       = 25;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] slot;
        logic [CALL_W-1:0] call;
        logic              failed;
        logic [TS_W-1:0]   ts;
    } t_event;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        t_stat_row           row;
    } t_result;

    typedef struct {
        logic [OP_W-1:0]     op;
        logic [SLOT_W-1:0]   slot;
        logic [CALL_W-1:0]   call;
        logic                failed;
        logic [TS_W-1:0]     ts;
        logic                typed;
        logic [STATUS_W-1:0] status;
        logic [TS_W-1:0]     time_ns;
        logic [CNT_W-1:0]    calls;
        logic [CNT_W-1:0]    errors;
        logic [CNT_W-1:0]    ments;
        logic [CNT_W-1:0]    mexits;
    } t_vector;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [OP_W-1:0]     i_op;
    logic [SLOT_W-1:0]   i_thread_slot;
    logic [CALL_W-1:0]   i_call_number;
    logic                i_call_failed;
    logic [TS_W-1:0]     i_timestamp_ns;
    logic                o_valid;
    logic                i_ready;
    logic [STATUS_W-1:0] o_status;
    logic [TS_W-1:0]     o_row_time_ns;
    logic [CNT_W-1:0]    o_row_calls;
    logic [CNT_W-1:0]    o_row_errors;
    logic [CNT_W-1:0]    o_row_missed_entries;
    logic [CNT_W-1:0]    o_row_missed_exits;

    // shadow of the thread table and the statistics rows
    bit               thr_valid   [THREAD_SLOTS];
    bit               thr_pending [THREAD_SLOTS];
    logic [CALL_W-1:0] thr_call   [THREAD_SLOTS];
    logic [TS_W-1:0]  thr_entry   [THREAD_SLOTS];
    t_stat_row        stats       [CALL_COUNT];

    t_result   due_results[$];
    t_vector   plan [0:N_PLAN-1];
    bit        idle_on = 1'b1;
    int        fail_count = 0;
    int        result_count = 0;
    logic [TS_W-1:0] clock_ns;

    syscall_entry_exit_profiler dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_op                 (i_op),
        .i_thread_slot        (i_thread_slot),
        .i_call_number        (i_call_number),
        .i_call_failed        (i_call_failed),
        .i_timestamp_ns       (i_timestamp_ns),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_status             (o_status),
        .o_row_time_ns        (o_row_time_ns),
        .o_row_calls          (o_row_calls),
        .o_row_errors         (o_row_errors),
        .o_row_missed_entries (o_row_missed_entries),
        .o_row_missed_exits   (o_row_missed_exits)
    );

    function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
        if (v == 32'hFFFF_FFFF) begin
            return v;
        end
        return v + 32'd1;
    endfunction

    // Apply one event to the shadow state and return the result it earns.
    function automatic t_result profile_event(input t_event ev);
        t_result         r;
        logic [TS_W-1:0] elapsed;
        r.status = ST_DONE;
        r.row    = '0;
        case (ev.op)
            OP_ENTRY: begin
                if (!thr_valid[ev.slot]) begin
                    thr_valid[ev.slot]   = 1'b1;
                    thr_pending[ev.slot] = 1'b0;
                end
                if (thr_pending[ev.slot]) begin
                    stats[ev.call].missed_exits = count_up(stats[ev.call].missed_exits);
                    r.status = ST_MISSED_EXIT;
                end
                thr_pending[ev.slot] = 1'b1;
                thr_call[ev.slot]    = ev.call;
                thr_entry[ev.slot]   = ev.ts;
            end
            OP_EXIT: begin
                if (!thr_valid[ev.slot]) begin
                    thr_valid[ev.slot]   = 1'b1;
                    thr_pending[ev.slot] = 1'b0;
                    r.status = ST_REGISTERED;
                end else if (!thr_pending[ev.slot]) begin
                    stats[ev.call].missed_entries = count_up(stats[ev.call].missed_entries);
                    r.status = ST_MISSED_ENTRY;
                end else if (thr_call[ev.slot] != ev.call) begin
                    stats[thr_call[ev.slot]].missed_exits =
                        count_up(stats[thr_call[ev.slot]].missed_exits);
                    stats[ev.call].missed_entries = count_up(stats[ev.call].missed_entries);
                    r.status = ST_MISMATCH;
                end else begin
                    elapsed = ev.ts - thr_entry[ev.slot];
                    // clamp when the sum would pass the top of the range
                    if (elapsed > ~stats[ev.call].time_ns) begin
                        stats[ev.call].time_ns = TS_TOP;
                    end else begin
                        stats[ev.call].time_ns = stats[ev.call].time_ns + elapsed;
                    end
                    if (ev.failed) begin
                        stats[ev.call].errors = count_up(stats[ev.call].errors);
                    end
                    stats[ev.call].calls = count_up(stats[ev.call].calls);
                    thr_pending[ev.slot] = 1'b0;
                    r.status = ST_COUNTED;
                end
            end
            OP_CREATE: begin
                thr_valid[ev.slot]   = 1'b1;
                thr_pending[ev.slot] = 1'b0;
                r.status = ST_REGISTERED;
            end
            OP_EXITED: begin
                thr_valid[ev.slot]   = 1'b0;
                thr_pending[ev.slot] = 1'b0;
            end
            OP_READ: begin
                r.row = stats[ev.call];
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic logic [CALL_W-1:0] pick_call();
        if ($urandom_range(0, 9) == 0) begin
            return CALL_W'($urandom_range(0, CALL_COUNT - 1));
        end
        return CALL_W'($urandom_range(0, 15));
    endfunction

    // Offer one transaction and record its expected result once it is taken.
    task automatic offer(input t_event ev, input logic typed, input t_result want);
        int      gap;
        t_result got;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_op           <= ev.op;
        i_thread_slot  <= ev.slot;
        i_call_number  <= ev.call;
        i_call_failed  <= ev.failed;
        i_timestamp_ns <= ev.ts;
        do @(posedge i_clk); while (!o_ready);
        got = profile_event(ev);
        due_results.push_back(typed ? want : got);
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= 10) begin
                $display("mismatch on %s: expected %h, got %h", name, want, got);
            end
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #400000;
        $display("syscall_entry_exit_profiler regression: fail");
        $finish;
    end

    // Result side: random stalls, one long hold-off to back the block up.
    initial begin
        int      stall;
        t_result got;
        t_result want;
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = idle_on ? $urandom_range(0, 3) : 0;
            if (result_count == HOLD_AT) begin
                stall = HOLD_CYCLES;
            end
            @(negedge i_clk);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            got.status             = o_status;
            got.row.time_ns        = o_row_time_ns;
            got.row.calls          = o_row_calls;
            got.row.errors         = o_row_errors;
            got.row.missed_entries = o_row_missed_entries;
            got.row.missed_exits   = o_row_missed_exits;
            result_count++;
            if (due_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("result with nothing expected: status %0d", got.status);
                end
            end else begin
                want = due_results.pop_front();
                compare_field("status", 64'(want.status), 64'(got.status));
                compare_field("row_time_ns", want.row.time_ns, got.row.time_ns);
                compare_field("row_calls", 64'(want.row.calls), 64'(got.row.calls));
                compare_field("row_errors", 64'(want.row.errors), 64'(got.row.errors));
                compare_field("row_missed_entries", 64'(want.row.missed_entries),
                              64'(got.row.missed_entries));
                compare_field("row_missed_exits", 64'(want.row.missed_exits),
                              64'(got.row.missed_exits));
            end
        end
    end

    // Event side: directed rows first, then random traffic.
    initial begin
        t_event  ev;
        t_result want;
        int      done_cnt;
        int      pick;
        int      s;
        i_valid        = 1'b0;
        i_op           = OP_ENTRY;
        i_thread_slot  = '0;
        i_call_number  = '0;
        i_call_failed  = 1'b0;
        i_timestamp_ns = '0;
        foreach (stats[c]) begin
            stats[c] = '0;
        end
        foreach (thr_call[t]) begin
            thr_call[t]  = '0;
            thr_entry[t] = '0;
        end
        clock_ns = {$urandom, $urandom};

        plan = '{
            // nothing counted yet
            '{OP_READ,     6'd0,  9'd0,   1'b0, TS_ZERO, 1'b1, ST_DONE, TS_ZERO, 0, 0, 0, 0},
            '{OP_READ,     6'd0,  9'd511, 1'b1, TS_TOP,  1'b1, ST_DONE, TS_ZERO, 0, 0, 0, 0},
            // exit on an unknown thread, then an exit with nothing open
            '{OP_EXIT,     6'd0,  9'd5,   1'b0, 64'd10,  1'b1, ST_REGISTERED, TS_ZERO, 0, 0, 0, 0},
            '{OP_EXIT,     6'd0,  9'd5,   1'b0, 64'd20,  1'b1, ST_MISSED_ENTRY, TS_ZERO, 0, 0, 0, 0},
            '{OP_ENTRY,    6'd0,  9'd5,   1'b0, TS_ZERO, 1'b1, ST_DONE, TS_ZERO, 0, 0, 0, 0},
            '{OP_ENTRY,    6'd0,  9'd6,   1'b0, TS_ZERO, 1'b1, ST_MISSED_EXIT, TS_ZERO, 0, 0, 0, 0},
            '{OP_EXIT,     6'd0,  9'd5,   1'b1, 64'd50,  1'b1, ST_MISMATCH, TS_ZERO, 0, 0, 0, 0},
            // two full-range calls drive the time sum into saturation
            '{OP_EXIT,     6'd0,  9'd6,   1'b1, TS_TOP,  1'b1, ST_COUNTED, TS_ZERO, 0, 0, 0, 0},
            '{OP_ENTRY,    6'd0,  9'd6,   1'b0, TS_ZERO, 1'b1, ST_DONE, TS_ZERO, 0, 0, 0, 0},
            '{OP_EXIT,     6'd0,  9'd6,   1'b0, TS_TOP,  1'b1, ST_COUNTED, TS_ZERO, 0, 0, 0, 0},
            '{OP_READ,     6'd0,  9'd6,   1'b0, TS_ZERO, 1'b1, ST_DONE, TS_TOP, 2, 1, 0, 2},
            '{OP_READ,     6'd0,  9'd5,   1'b0, TS_ZERO, 1'b1, ST_DONE, TS_ZERO, 0, 0, 2, 0},
            // timestamp wraps between entry and exit
            '{OP_CREATE,   6'd63, 9'd0,   1'b0, TS_ZERO, 1'b1, ST_REGISTERED, TS_ZERO, 0, 0, 0, 0},
            '{OP_ENTRY,    6'd63, 9'd511, 1'b0, TS_TOP,  1'b0, ST_DONE, TS_ZERO, 0, 0, 0, 0},
            '{OP_EXIT,     6'd63, 9'd511, 1'b1, 64'd5,   1'b0, ST_DONE, TS_ZERO, 0, 0, 0, 0},
            '{OP_READ,     6'd63, 9'd511, 1'b0, TS_ZERO, 1'b1, ST_DONE, 64'd6, 1, 1, 0, 0},
            // entry registers a fresh thread; a dead thread forgets its call
            '{OP_ENTRY,    6'd62, 9'd3,   1'b0, 64'd100, 1'b0, ST_DONE, TS_ZERO, 0, 0, 0, 0},
            '{OP_EXITED,   6'd62, 9'd3,   1'b0, 64'd150, 1'b1, ST_DONE, TS_ZERO, 0, 0, 0, 0},
            '{OP_EXIT,     6'd62, 9'd3,   1'b0, 64'd200, 1'b1, ST_REGISTERED, TS_ZERO, 0, 0, 0, 0},
            // re-creating a live thread drops its open call
            '{OP_ENTRY,    6'd0,  9'd7,   1'b0, 64'd300, 1'b0, ST_DONE, TS_ZERO, 0, 0, 0, 0},
            '{OP_CREATE,   6'd0,  9'd7,   1'b0, 64'd350, 1'b1, ST_REGISTERED, TS_ZERO, 0, 0, 0, 0},
            '{OP_EXIT,     6'd0,  9'd7,   1'b0, 64'd400, 1'b1, ST_MISSED_ENTRY, TS_ZERO, 0, 0, 0, 0},
            '{OP_SPARE_HI, 6'd5,  9'd9,   1'b0, 64'd500, 1'b1, ST_DONE, TS_ZERO, 0, 0, 0, 0},
            '{OP_SPARE_LO, 6'd63, 9'd511, 1'b1, TS_TOP,  1'b1, ST_DONE, TS_ZERO, 0, 0, 0, 0},
            '{OP_READ,     6'd0,  9'd7,   1'b0, TS_ZERO, 1'b1, ST_DONE, TS_ZERO, 0, 0, 1, 0}
        };

        wait (i_rst_n === 1'b1);

        foreach (plan[k]) begin
            ev.op                  = plan[k].op;
            ev.slot                = plan[k].slot;
            ev.call                = plan[k].call;
            ev.failed              = plan[k].failed;
            ev.ts                  = plan[k].ts;
            want.status            = plan[k].status;
            want.row.time_ns       = plan[k].time_ns;
            want.row.calls         = plan[k].calls;
            want.row.errors        = plan[k].errors;
            want.row.missed_entries = plan[k].ments;
            want.row.missed_exits  = plan[k].mexits;
            offer(ev, plan[k].typed, want);
        end

        done_cnt = 0;
        while (done_cnt < N_RANDOM) begin
            // a stretch with no gaps on either side
            idle_on = !(done_cnt >= 150 && done_cnt < 220);
            pick = $urandom_range(0, 99);
            s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, THREAD_SLOTS - 1)
                                             : $urandom_range(0, 7);
            clock_ns += 64'($urandom_range(1, 5000));
            ev.slot   = SLOT_W'(s);
            ev.failed = 1'($urandom_range(0, 1));
            ev.ts     = clock_ns;
            ev.call   = pick_call();
            if (pick < 60) begin
                // close the open call on this thread (or open one), now and then with a stray number
                ev.op = thr_pending[s] ? OP_EXIT : OP_ENTRY;
                if (thr_pending[s] && $urandom_range(0, 9) != 0) begin
                    ev.call = thr_call[s];
                end
            end else if (pick < 75) begin
                ev.op = OP_READ;
            end else if (pick < 80) begin
                ev.op = (pick < 78) ? OP_CREATE : OP_EXITED;
            end else begin
                ev.op   = OP_W'($urandom_range(0, 7));
                ev.call = CALL_W'($urandom_range(0, CALL_COUNT - 1));
                ev.ts   = {$urandom, $urandom};
            end
            if (ev.op <= OP_READ) begin
                done_cnt++;
            end
            offer(ev, 1'b0, '0);
        end
        idle_on = 1'b1;

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("syscall_entry_exit_profiler regression: pass");
        end else begin
            $display("syscall_entry_exit_profiler regression: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/scprof_pkg.sv
sv/scprof_ram.sv
sv/scprof_ctrl.sv
sv/scprof_dp.sv
sv/syscall_entry_exit_profiler.sv
dv/tb.sv
